@@ hdl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types, codes and widths of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TOL_WIDTH     = 32;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2,
        KIND_INF  = 2'd3
    } root_kind_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } qrs_coef_t;

    typedef struct packed {
        root_kind_t                   root_kind;
        logic signed [COEF_WIDTH-1:0] root_one;
        logic signed [COEF_WIDTH-1:0] root_two;
        logic                         overflow;
    } qrs_root_t;

    // Classified item as it leaves the front end and rides along the square root.
    typedef struct packed {
        root_kind_t            kind;
        logic                  lin;
        logic                  an;
        logic                  bn;
        logic                  cn;
        logic [COEF_WIDTH-1:0] am;
        logic [COEF_WIDTH-1:0] bm;
        logic [COEF_WIDTH-1:0] cm;
    } qrs_mid_t;

    // Sideband carried along the divider.
    typedef struct packed {
        root_kind_t kind;
        logic       neg1;
        logic       neg2;
    } qrs_dside_t;

endpackage

@@ hdl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one coefficient beat per cycle unless a finished root beat is held,
// and returns one root beat per beat, in order, through three front stages
// for magnitudes, products and discriminant, one stage per bit of the square
// root, one numerator stage, one stage per quotient bit of the dual divider
// and one output stage. The whole pipeline holds while a finished root beat
// is stalled. The tolerance is a discriminant magnitude in units of
// 2^-(2*FRAC_BITS); write it only while no beats are in flight.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coef_valid,
    output logic                 coef_stall,
    input  qrs_coef_t            coef,
    output logic                 root_valid,
    input  logic                 root_stall,
    output qrs_root_t            root,
    input  logic                 cfg_we,
    input  logic [TOL_WIDTH-1:0] cfg_data
);

    localparam int CW  = COEF_WIDTH;
    localparam int DDW = 2 * CW + 2;
    localparam int RB  = CW + 1;
    localparam int NMW = CW + 2;
    localparam int NW  = NMW + FRAC_BITS;
    localparam int DVW = CW + 1;
    localparam int MW  = $bits(qrs_mid_t);
    localparam int DSW = $bits(qrs_dside_t);

    logic                 en;
    logic [TOL_WIDTH-1:0] tol_reg;

    logic           fr_valid;
    qrs_mid_t       fr_mid;
    logic [DDW-1:0] fr_dmag;

    logic           sq_valid;
    logic [RB-1:0]  sq_root;
    logic [MW-1:0]  sq_side;
    qrs_mid_t       sm;

    logic           vn_reg;
    logic [NMW-1:0] num1_reg, num2_reg, num1_next, num2_next;
    logic [DVW-1:0] dv_reg, dv_next;
    qrs_dside_t     ds_reg, ds_next;

    logic           dv_valid;
    logic [NW-1:0]  quo1, quo2;
    logic [DSW-1:0] dv_side;
    qrs_dside_t     dso;

    logic           root_valid_reg;
    qrs_root_t      root_reg, root_next;

    // advance everything unless a finished beat is held
    assign en         = !root_valid_reg || !root_stall;
    assign coef_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_data;
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_valid),
        .coef      (coef),
        .tol       (tol_reg),
        .out_valid (fr_valid),
        .mid       (fr_mid),
        .dmag      (fr_dmag)
    );

    qrs_sqrt_pipe #(
        .NB (DDW),
        .SW (MW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .n_in      (fr_dmag),
        .side_in   (fr_mid),
        .out_valid (sq_valid),
        .root_out  (sq_root),
        .side_out  (sq_side)
    );

    assign sm = sq_side;

    // numerator and divisor in sign-magnitude form
    always_comb
    begin
        logic [NMW-1:0] b_x, s_x;
        logic           sg1, sg2, dsg;
        b_x       = NMW'(sm.bm);
        s_x       = NMW'(sq_root);
        num1_next = b_x;
        num2_next = b_x;
        sg1       = !sm.bn;
        sg2       = !sm.bn;
        dv_next   = {sm.am, 1'b0};
        dsg       = sm.an;
        if (sm.lin)
        begin
            num1_next = NMW'(sm.cm);
            num2_next = NMW'(sm.cm);
            sg1       = !sm.cn;
            sg2       = !sm.cn;
            dv_next   = DVW'(sm.bm);
            dsg       = sm.bn;
        end
        else if (sm.kind == KIND_TWO)
        begin
            // -b + s
            if (sm.bn)
            begin
                num1_next = b_x + s_x;
                sg1       = 1'b0;
            end
            else if (b_x >= s_x)
            begin
                num1_next = b_x - s_x;
                sg1       = 1'b1;
            end
            else
            begin
                num1_next = s_x - b_x;
                sg1       = 1'b0;
            end
            // -b - s
            if (!sm.bn)
            begin
                num2_next = b_x + s_x;
                sg2       = 1'b1;
            end
            else if (b_x >= s_x)
            begin
                num2_next = b_x - s_x;
                sg2       = 1'b0;
            end
            else
            begin
                num2_next = s_x - b_x;
                sg2       = 1'b1;
            end
        end
        ds_next.kind = sm.kind;
        ds_next.neg1 = sg1 ^ dsg;
        ds_next.neg2 = sg2 ^ dsg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vn_reg <= 1'b0;
        else if (en)
            vn_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= num1_next;
            num2_reg <= num2_next;
            dv_reg   <= dv_next;
            ds_reg   <= ds_next;
        end
    end

    qrs_div_pipe #(
        .NW (NW),
        .DW (DVW),
        .SW (DSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vn_reg),
        .num1      ({num1_reg, {FRAC_BITS{1'b0}}}),
        .num2      ({num2_reg, {FRAC_BITS{1'b0}}}),
        .dvs       (dv_reg),
        .side_in   (ds_reg),
        .out_valid (dv_valid),
        .quo1      (quo1),
        .quo2      (quo2),
        .side_out  (dv_side)
    );

    assign dso = dv_side;

    // clamp to the signed range; the top bit is the overflow flag
    function automatic logic [CW:0] sat(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        logic [NW-1:0] mag;
        logic          ovf;
        lim = (NW'(1) << (CW - 1)) - (neg ? NW'(0) : NW'(1));
        ovf = (q > lim);
        mag = ovf ? lim : q;
        return {ovf, CW'(neg ? (~mag + 1'b1) : mag)};
    endfunction

    always_comb
    begin
        logic [CW:0] s1, s2;
        s1 = sat(quo1, dso.neg1);
        s2 = sat(quo2, dso.neg2);
        root_next.root_kind = dso.kind;
        root_next.root_one  = '0;
        root_next.root_two  = '0;
        root_next.overflow  = 1'b0;
        unique case (dso.kind)
            KIND_ONE:
            begin
                root_next.root_one = s1[CW-1:0];
                root_next.root_two = s1[CW-1:0];
                root_next.overflow = s1[CW];
            end
            KIND_TWO:
            begin
                root_next.root_one = s1[CW-1:0];
                root_next.root_two = s2[CW-1:0];
                root_next.overflow = s1[CW] | s2[CW];
            end
            KIND_NONE, KIND_INF:
            begin
                root_next.overflow = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_valid_reg <= 1'b0;
        else if (en)
            root_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            root_reg <= root_next;
    end

    assign root_valid = root_valid_reg;
    assign root       = root_reg;

    a_one_root_equal: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root.root_kind == KIND_ONE) |-> root.root_two == root.root_one)
        else $error("single root beat with differing roots");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root.root_kind == KIND_NONE || root.root_kind == KIND_INF)
        |-> root.root_one == '0 && root.root_two == '0 && !root.overflow)
        else $error("rootless beat carries nonzero fields");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !root_valid |-> !coef_stall)
        else $error("input stalled with empty output");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> $stable(vn_reg) && $stable(dv_valid))
        else $error("pipeline moved while output held");

endmodule

@@ hdl/qrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Magnitudes, products and discriminant over three register stages; sorts
// each item into its root kind.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  qrs_coef_t                 coef,
    input  logic [TOL_WIDTH-1:0]      tol,
    output logic                      out_valid,
    output qrs_mid_t                  mid,
    output logic [2*COEF_WIDTH+1:0]   dmag
);

    localparam int CW = COEF_WIDTH;
    localparam int PW = 2 * CW;
    localparam int DW = 2 * CW + 2;

    function automatic logic [CW-1:0] mag_of(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    // stage A: sign and magnitude
    logic          va_reg;
    logic          an_reg, bn_reg, cn_reg;
    logic [CW-1:0] am_reg, bm_reg, cm_reg;

    // stage B: products
    logic          vb_reg;
    logic          anb_reg, bnb_reg, cnb_reg;
    logic [CW-1:0] amb_reg, bmb_reg, cmb_reg;
    logic [PW-1:0] bsq_reg, ac_reg;
    logic [PW-1:0] bsq_next, ac_next;

    // stage C: discriminant and kind
    logic          vc_reg;
    qrs_mid_t      mid_reg, mid_next;
    logic [DW-1:0] dmag_reg, dmag_next;

    assign bsq_next = bm_reg * bm_reg;
    assign ac_next  = am_reg * cm_reg;

    always_comb
    begin
        logic [DW-1:0] fac;
        logic [DW-1:0] bsq;
        logic          dneg;
        fac  = {ac_reg, 2'b00};
        bsq  = {2'b00, bsq_reg};
        dneg = 1'b0;
        if (anb_reg != cnb_reg)
        begin
            dmag_next = bsq + fac;
        end
        else if (bsq >= fac)
        begin
            dmag_next = bsq - fac;
        end
        else
        begin
            dneg      = 1'b1;
            dmag_next = fac - bsq;
        end

        mid_next.an = anb_reg;
        mid_next.bn = bnb_reg;
        mid_next.cn = cnb_reg;
        mid_next.am = amb_reg;
        mid_next.bm = bmb_reg;
        mid_next.cm = cmb_reg;
        if (amb_reg == '0)
        begin
            mid_next.lin = 1'b1;
            if (bmb_reg != '0)
                mid_next.kind = KIND_ONE;
            else if (cmb_reg == '0)
                mid_next.kind = KIND_INF;
            else
                mid_next.kind = KIND_NONE;
        end
        else
        begin
            mid_next.lin = 1'b0;
            if (dmag_next <= DW'(tol))
                mid_next.kind = KIND_ONE;
            else if (!dneg)
                mid_next.kind = KIND_TWO;
            else
                mid_next.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg   <= coef.coef_a[CW-1];
            bn_reg   <= coef.coef_b[CW-1];
            cn_reg   <= coef.coef_c[CW-1];
            am_reg   <= mag_of(coef.coef_a);
            bm_reg   <= mag_of(coef.coef_b);
            cm_reg   <= mag_of(coef.coef_c);
            anb_reg  <= an_reg;
            bnb_reg  <= bn_reg;
            cnb_reg  <= cn_reg;
            amb_reg  <= am_reg;
            bmb_reg  <= bm_reg;
            cmb_reg  <= cm_reg;
            bsq_reg  <= bsq_next;
            ac_reg   <= ac_next;
            mid_reg  <= mid_next;
            dmag_reg <= dmag_next;
        end
    end

    assign out_valid = vc_reg;
    assign mid       = mid_reg;
    assign dmag      = dmag_reg;

endmodule

@@ hdl/qrs_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe
// Integer square root, rounded down, one result bit per register stage.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe #(
    parameter int NB = 66,
    parameter int SW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NB-1:0]     n_in,
    input  logic [SW-1:0]     side_in,
    output logic              out_valid,
    output logic [NB/2-1:0]   root_out,
    output logic [SW-1:0]     side_out
);

    localparam int RB  = NB / 2;
    localparam int RMW = RB + 3;

    logic [RMW-1:0] rem_reg  [RB];
    logic [RB-1:0]  root_reg [RB];
    logic [NB-1:0]  n_reg    [RB];
    logic [SW-1:0]  side_reg [RB];
    logic           valid_reg[RB];

    for (genvar i = 0; i < RB; i++)
    begin : g_stage
        logic [RMW-1:0] rem_p, rem_sh, trial;
        logic [RB-1:0]  root_p;
        logic [NB-1:0]  n_p;
        logic [SW-1:0]  side_p;
        logic           v_p, take;

        if (i == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign n_p    = n_in;
            assign side_p = side_in;
            assign v_p    = in_valid;
        end
        else
        begin : g_rest
            assign rem_p  = rem_reg[i-1];
            assign root_p = root_reg[i-1];
            assign n_p    = n_reg[i-1];
            assign side_p = side_reg[i-1];
            assign v_p    = valid_reg[i-1];
        end

        // bring down the next two bits and try root*4+1
        assign rem_sh = {rem_p[RMW-3:0], n_p[NB-1 -: 2]};
        assign trial  = {1'b0, root_p, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_p[RB-2:0], take};
                n_reg[i]    <= n_p << 2;
                side_reg[i] <= side_p;
            end
        end
    end

    assign out_valid = valid_reg[RB-1];
    assign root_out  = root_reg[RB-1];
    assign side_out  = side_reg[RB-1];

endmodule

@@ hdl/qrs_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div_pipe
// Two restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div_pipe #(
    parameter int NW = 50,
    parameter int DW = 33,
    parameter int SW = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num1,
    input  logic [NW-1:0]   num2,
    input  logic [DW-1:0]   dvs,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [NW-1:0]   quo1,
    output logic [NW-1:0]   quo2,
    output logic [SW-1:0]   side_out
);

    localparam int RW = DW + 1;

    logic [DW-1:0] r1_reg  [NW];
    logic [DW-1:0] r2_reg  [NW];
    logic [NW-1:0] q1_reg  [NW];
    logic [NW-1:0] q2_reg  [NW];
    logic [NW-1:0] n1_reg  [NW];
    logic [NW-1:0] n2_reg  [NW];
    logic [DW-1:0] d_reg   [NW];
    logic [SW-1:0] side_reg[NW];
    logic          valid_reg[NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DW-1:0] r1_p, r2_p, d_p;
        logic [NW-1:0] q1_p, q2_p, n1_p, n2_p;
        logic [SW-1:0] side_p;
        logic          v_p, take1, take2;
        logic [RW-1:0] sh1, sh2, dx;

        if (i == 0)
        begin : g_first
            assign r1_p   = '0;
            assign r2_p   = '0;
            assign q1_p   = '0;
            assign q2_p   = '0;
            assign n1_p   = num1;
            assign n2_p   = num2;
            assign d_p    = dvs;
            assign side_p = side_in;
            assign v_p    = in_valid;
        end
        else
        begin : g_rest
            assign r1_p   = r1_reg[i-1];
            assign r2_p   = r2_reg[i-1];
            assign q1_p   = q1_reg[i-1];
            assign q2_p   = q2_reg[i-1];
            assign n1_p   = n1_reg[i-1];
            assign n2_p   = n2_reg[i-1];
            assign d_p    = d_reg[i-1];
            assign side_p = side_reg[i-1];
            assign v_p    = valid_reg[i-1];
        end

        assign dx    = {1'b0, d_p};
        assign sh1   = {r1_p, n1_p[NW-1]};
        assign sh2   = {r2_p, n2_p[NW-1]};
        assign take1 = (sh1 >= dx);
        assign take2 = (sh2 >= dx);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r1_reg[i]   <= DW'(take1 ? (sh1 - dx) : sh1);
                r2_reg[i]   <= DW'(take2 ? (sh2 - dx) : sh2);
                q1_reg[i]   <= {q1_p[NW-2:0], take1};
                q2_reg[i]   <= {q2_p[NW-2:0], take2};
                n1_reg[i]   <= n1_p << 1;
                n2_reg[i]   <= n2_p << 1;
                d_reg[i]    <= d_p;
                side_reg[i] <= side_p;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quo1      = q1_reg[NW-1];
    assign quo2      = q2_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule
